[rtl/core/coil_duty_power_limiter_unit_defines.svh]
// assertion macros for the coil duty power limiter
// expects signals named clk and rst in the using module
`ifndef COIL_DUTY_POWER_LIMITER_UNIT_DEFINES_SVH
`define COIL_DUTY_POWER_LIMITER_UNIT_DEFINES_SVH

// same-cycle implication
`define CDPL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CDPL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/cdpl_pkg.sv]
// shared types and constants for the coil duty power limiter
// no dependencies
`default_nettype none

package cdpl_pkg;

  localparam int DUTY_FRAC_BITS_DEF = 14;
  localparam int AXES = 3;
  localparam int MAG_W = 16;
  localparam int VOLT_W = 16;
  localparam int CFG_W = 16;
  localparam int CFG_ADDR_W = 3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_WORST_V = 3'd0,
    CFG_RES_X   = 3'd1,
    CFG_RES_Y   = 3'd2,
    CFG_RES_Z   = 3'd3,
    CFG_BUDGET  = 3'd4,
    CFG_GAIN    = 3'd5
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] RST_WORST_V = 16'd8400;
  localparam logic [CFG_W-1:0] RST_RES     = 16'd30000;
  localparam logic [CFG_W-1:0] RST_BUDGET  = 16'd1000;
  localparam logic [CFG_W-1:0] RST_GAIN    = 16'd1000;

  typedef logic [AXES-1:0][MAG_W-1:0] mag_vec_t;

  typedef struct packed {
    logic [AXES-1:0]   neg;
    logic [VOLT_W-1:0] volt;
    logic              clamped;
    mag_vec_t          mag;
  } clamp_side_t;

  typedef struct packed {
    logic [AXES-1:0]   neg;
    logic [VOLT_W-1:0] volt;
    logic              clamped;
    logic              limited;
    mag_vec_t          mag;
  } limit_side_t;

  typedef struct packed {
    logic [AXES-1:0] neg;
    logic            clamped;
    logic            limited;
    mag_vec_t        mag;
  } out_side_t;

endpackage

`default_nettype wire

[rtl/core/cdpl_div_pipe.sv]
// pipelined restoring divider, one quotient bit per stage, several lanes in lockstep
// standalone, carries a sideband word along with each request
`default_nettype none

module cdpl_div_pipe #(
  parameter int LANES  = 1,
  parameter int NUM_W  = 8,
  parameter int DEN_W  = 8,
  parameter int QW     = 8,
  parameter int SIDE_W = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [LANES-1:0][NUM_W-1:0] num,
  input  logic [LANES-1:0][DEN_W-1:0] den,
  input  logic [SIDE_W-1:0]           in_side,
  output logic                        out_valid,
  output logic [LANES-1:0][QW-1:0]    quo,
  output logic [SIDE_W-1:0]           out_side
);

  localparam int WW = (NUM_W > DEN_W + QW) ? NUM_W : DEN_W + QW;

  logic                        vld  [1:QW];
  logic [LANES-1:0][WW-1:0]    rem  [1:QW];
  logic [LANES-1:0][DEN_W-1:0] dvs  [1:QW];
  logic [LANES-1:0][QW-1:0]    qacc [1:QW];
  logic [SIDE_W-1:0]           side [1:QW];

  genvar k;
  for (k = 0; k < QW; k++) begin : g_stage
    localparam int SH = QW - 1 - k;
    logic                        cur_vld;
    logic [LANES-1:0][WW-1:0]    cur_rem;
    logic [LANES-1:0][WW-1:0]    rem_next;
    logic [LANES-1:0][DEN_W-1:0] cur_dvs;
    logic [LANES-1:0][QW-1:0]    cur_q;
    logic [LANES-1:0][QW-1:0]    q_next;
    logic [SIDE_W-1:0]           cur_side;

    if (k == 0) begin : g_src
      always_comb begin
        cur_vld = in_valid;
        for (int l = 0; l < LANES; l++) begin
          cur_rem[l] = WW'(num[l]);
        end
        cur_dvs  = den;
        cur_q    = '0;
        cur_side = in_side;
      end
    end else begin : g_src
      assign cur_vld  = vld[k];
      assign cur_rem  = rem[k];
      assign cur_dvs  = dvs[k];
      assign cur_q    = qacc[k];
      assign cur_side = side[k];
    end

    always_comb begin
      logic [WW:0] diff;
      diff = '0;
      for (int l = 0; l < LANES; l++) begin
        diff = {1'b0, cur_rem[l]} - ({1'b0, WW'(cur_dvs[l])} << SH);
        q_next[l] = cur_q[l];
        if (!diff[WW]) begin
          rem_next[l] = diff[WW-1:0];
          q_next[l][SH] = 1'b1;
        end else begin
          rem_next[l] = cur_rem[l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= rem_next;
        dvs[k+1]  <= cur_dvs;
        qacc[k+1] <= q_next;
        side[k+1] <= cur_side;
      end
    end
  end

  assign out_valid = vld[QW];
  assign quo       = qacc[QW];
  assign out_side  = side[QW];

endmodule

`default_nettype wire

[rtl/core/cdpl_sqrt_pipe.sv]
// pipelined integer square root, one root bit per stage
// standalone, carries a sideband word along with each request
`default_nettype none

module cdpl_sqrt_pipe #(
  parameter int RW     = 16,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*RW-1:0]   rad,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [RW-1:0]     root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int VW = 2 * RW;

  logic              vld  [1:RW];
  logic [VW-1:0]     val  [1:RW];
  logic [VW-1:0]     acc  [1:RW];
  logic [SIDE_W-1:0] side [1:RW];

  genvar k;
  for (k = 0; k < RW; k++) begin : g_stage
    localparam logic [VW-1:0] BITV = VW'(1) << (2 * (RW - 1 - k));
    logic              cur_vld;
    logic [VW-1:0]     cur_v;
    logic [VW-1:0]     cur_r;
    logic [SIDE_W-1:0] cur_side;
    logic [VW:0]       trial;
    logic [VW-1:0]     v_next;
    logic [VW-1:0]     r_next;

    if (k == 0) begin : g_src
      assign cur_vld  = in_valid;
      assign cur_v    = rad;
      assign cur_r    = '0;
      assign cur_side = in_side;
    end else begin : g_src
      assign cur_vld  = vld[k];
      assign cur_v    = val[k];
      assign cur_r    = acc[k];
      assign cur_side = side[k];
    end

    always_comb begin
      trial = {1'b0, cur_r} + {1'b0, BITV};
      if ({1'b0, cur_v} >= trial) begin
        v_next = cur_v - trial[VW-1:0];
        r_next = (cur_r >> 1) + BITV;
      end else begin
        v_next = cur_v;
        r_next = cur_r >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        val[k+1]  <= v_next;
        acc[k+1]  <= r_next;
        side[k+1] <= cur_side;
      end
    end
  end

  assign out_valid = vld[RW];
  assign root      = acc[RW][RW-1:0];
  assign out_side  = side[RW];

endmodule

`default_nettype wire

[rtl/core/cdpl_power_est.sv]
// coil power estimate: sum over axes of (duty * volt)^2 / (one^2 * res)
// uses cdpl_pkg and cdpl_div_pipe
`default_nettype none

module cdpl_power_est #(
  parameter int FRAC   = cdpl_pkg::DUTY_FRAC_BITS_DEF,
  parameter int SIDE_W = 1,
  parameter int PW     = 64 - 2 * FRAC
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  cdpl_pkg::mag_vec_t             mag,
  input  logic [cdpl_pkg::VOLT_W-1:0]    volt,
  input  cdpl_pkg::mag_vec_t             res,
  input  logic [SIDE_W-1:0]              in_side,
  output logic                           out_valid,
  output logic [PW-1:0]                  power,
  output logic [SIDE_W-1:0]              out_side
);

  localparam int NUM_W = 31;
  localparam int DW    = 2 * NUM_W - 2 * FRAC;
  localparam int AX    = cdpl_pkg::AXES;

  logic                        va;
  logic [AX-1:0][NUM_W-1:0]    num_a;
  logic [SIDE_W-1:0]           side_a;
  logic                        vb;
  logic [AX-1:0][DW-1:0]       sq_b;
  logic [AX-1:0][15:0]         den_b;
  logic [SIDE_W-1:0]           side_b;
  logic                        dv;
  logic [AX-1:0][DW-1:0]       dq;
  logic [SIDE_W-1:0]           dside;
  logic [AX-1:0][NUM_W-1:0]    num_next;
  logic [AX-1:0][DW-1:0]       sq_next;
  logic [AX-1:0][15:0]         den_next;
  logic [PW-1:0]               sum_next;

  always_comb begin
    logic [31:0] prod;
    logic [61:0] sq;
    prod = '0;
    sq   = '0;
    for (int l = 0; l < AX; l++) begin
      prod        = {16'd0, mag[l]} * {16'd0, volt};
      num_next[l] = prod[NUM_W-1:0];
      sq          = {31'd0, num_a[l]} * {31'd0, num_a[l]};
      sq_next[l]  = sq[61:2*FRAC];
      den_next[l] = (res[l] == '0) ? 16'd1 : res[l];
    end
  end

  always_comb begin
    sum_next = PW'(dq[0]) + PW'(dq[1]) + PW'(dq[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va        <= in_valid;
      vb        <= va;
      out_valid <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_a    <= num_next;
      side_a   <= in_side;
      sq_b     <= sq_next;
      den_b    <= den_next;
      side_b   <= side_a;
      power    <= sum_next;
      out_side <= dside;
    end
  end

  cdpl_div_pipe #(
    .LANES  (AX),
    .NUM_W  (DW),
    .DEN_W  (16),
    .QW     (DW),
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vb),
    .num       (sq_b),
    .den       (den_b),
    .in_side   (side_b),
    .out_valid (dv),
    .quo       (dq),
    .out_side  (dside)
  );

endmodule

`default_nettype wire

[rtl/core/coil_duty_power_limiter_unit.sv]
// pipeline depth is set by the bit-per-stage dividers (clamp, two power estimates, budget ratio)
// and the 16-stage square root
// throughput: one request per cycle; the whole pipeline holds while the output is stalled
// reset: valid bits cleared, config registers load their defaults, no memory to clear
// uses cdpl_pkg, cdpl_div_pipe, cdpl_sqrt_pipe, cdpl_power_est
`default_nettype none
`include "coil_duty_power_limiter_unit_defines.svh"

module coil_duty_power_limiter_unit #(
  parameter int DUTY_FRAC_BITS = cdpl_pkg::DUTY_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [63:0]                     s_tdata,  // req_x, req_y, req_z, bus_voltage_mv
  input  logic                            s_tuser,  // monitor_alive
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // duty_x, duty_y, duty_z, moment_x, moment_y, moment_z, power_mw, zero pad
  output logic [119:0]                    m_tdata,
  output logic [1:0]                      m_tuser,  // was_clamped, was_power_limited
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cdpl_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [cdpl_pkg::CFG_W-1:0]      cfg_data
);

  localparam int F      = DUTY_FRAC_BITS;
  localparam int AX     = cdpl_pkg::AXES;
  localparam int MW     = cdpl_pkg::MAG_W;
  localparam int PW     = 64 - 2 * F;
  localparam int CN_W   = F + 18;
  localparam logic [31:0] ONE32 = 32'(1) << F;

  // config
  logic [15:0] cfg_worst_v;
  logic [15:0] cfg_budget;
  logic [15:0] cfg_gain;
  cdpl_pkg::mag_vec_t cfg_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_worst_v <= cdpl_pkg::RST_WORST_V;
      cfg_res     <= {AX{cdpl_pkg::RST_RES}};
      cfg_budget  <= cdpl_pkg::RST_BUDGET;
      cfg_gain    <= cdpl_pkg::RST_GAIN;
    end else if (cfg_valid) begin
      case (cdpl_pkg::cfg_reg_t'(cfg_addr))
        cdpl_pkg::CFG_WORST_V: cfg_worst_v <= cfg_data;
        cdpl_pkg::CFG_RES_X:   cfg_res[0]  <= cfg_data;
        cdpl_pkg::CFG_RES_Y:   cfg_res[1]  <= cfg_data;
        cdpl_pkg::CFG_RES_Z:   cfg_res[2]  <= cfg_data;
        cdpl_pkg::CFG_BUDGET:  cfg_budget  <= cfg_data;
        cdpl_pkg::CFG_GAIN:    cfg_gain    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // stage 1: magnitudes and voltage select
  logic               v1;
  cdpl_pkg::mag_vec_t mag1;
  logic [AX-1:0]      neg1;
  logic [15:0]        volt1;
  cdpl_pkg::mag_vec_t mag1_next;
  logic [AX-1:0]      neg1_next;

  always_comb begin
    logic [15:0] raw;
    raw = '0;
    for (int l = 0; l < AX; l++) begin
      raw          = s_tdata[16*l +: 16];
      neg1_next[l] = raw[15];
      mag1_next[l] = raw[15] ? (16'd0 - raw) : raw;
    end
  end

  // stage 2: largest magnitude
  logic                   v2;
  cdpl_pkg::mag_vec_t     mag2;
  logic [AX-1:0]          neg2;
  logic [15:0]            volt2;
  logic [MW-1:0]          max2;
  logic                   clamped2;
  logic [MW-1:0]          max01;
  logic [MW-1:0]          max_next;

  always_comb begin
    max01    = (mag1[0] > mag1[1]) ? mag1[0] : mag1[1];
    max_next = (max01 > mag1[2]) ? max01 : mag1[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag1     <= mag1_next;
      neg1     <= neg1_next;
      volt1    <= s_tuser ? s_tdata[63:48] : cfg_worst_v;
      mag2     <= mag1;
      neg2     <= neg1;
      volt2    <= volt1;
      max2     <= max_next;
      clamped2 <= {16'd0, max_next} > ONE32;
    end
  end

  // magnitude clamp divider
  logic [AX-1:0][CN_W-1:0] clamp_num;
  logic [AX-1:0][16:0]     clamp_den;
  cdpl_pkg::clamp_side_t   clamp_side_in;
  logic                    cv;
  logic [AX-1:0][F:0]      clamp_q;
  cdpl_pkg::clamp_side_t   clamp_side_out;

  always_comb begin
    for (int l = 0; l < AX; l++) begin
      clamp_num[l] = (CN_W'(mag2[l]) << (F + 1)) + CN_W'(max2);
      clamp_den[l] = {1'b0, max2} << 1;
    end
    clamp_side_in.neg     = neg2;
    clamp_side_in.volt    = volt2;
    clamp_side_in.clamped = clamped2;
    clamp_side_in.mag     = mag2;
  end

  cdpl_div_pipe #(
    .LANES  (AX),
    .NUM_W  (CN_W),
    .DEN_W  (17),
    .QW     (F + 1),
    .SIDE_W ($bits(cdpl_pkg::clamp_side_t))
  ) u_clamp_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v2),
    .num       (clamp_num),
    .den       (clamp_den),
    .in_side   (clamp_side_in),
    .out_valid (cv),
    .quo       (clamp_q),
    .out_side  (clamp_side_out)
  );

  // first power estimate on clamped duties
  cdpl_pkg::clamp_side_t pe1_side_in;
  cdpl_pkg::clamp_side_t pe1_side_out;
  logic                  pe1_v;
  logic [PW-1:0]         pe1_power;

  always_comb begin
    pe1_side_in = clamp_side_out;
    for (int l = 0; l < AX; l++) begin
      pe1_side_in.mag[l] = clamp_side_out.clamped ? MW'(clamp_q[l]) : clamp_side_out.mag[l];
    end
  end

  cdpl_power_est #(
    .FRAC   (F),
    .SIDE_W ($bits(cdpl_pkg::clamp_side_t)),
    .PW     (PW)
  ) u_pe1 (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (cv),
    .mag       (pe1_side_in.mag),
    .volt      (pe1_side_in.volt),
    .res       (cfg_res),
    .in_side   (pe1_side_in),
    .out_valid (pe1_v),
    .power     (pe1_power),
    .out_side  (pe1_side_out)
  );

  // stage 5: budget compare
  logic                  v5;
  logic [PW-1:0]         p5;
  logic                  lim5;
  cdpl_pkg::limit_side_t side5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= pe1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p5            <= pe1_power;
      lim5          <= pe1_power > PW'(cfg_budget);
      side5.neg     <= pe1_side_out.neg;
      side5.volt    <= pe1_side_out.volt;
      side5.clamped <= pe1_side_out.clamped;
      side5.limited <= pe1_power > PW'(cfg_budget);
      side5.mag     <= pe1_side_out.mag;
    end
  end

  // budget / power ratio, then its square root
  logic [0:0][47:0]      bud_num;
  logic [0:0][PW-1:0]    bud_den;
  logic                  bv;
  logic [0:0][31:0]      bud_q;
  cdpl_pkg::limit_side_t bud_side;
  logic                  sv;
  logic [15:0]           scale;
  cdpl_pkg::limit_side_t sq_side;

  assign bud_num[0] = {cfg_budget, 32'd0};
  assign bud_den[0] = p5;

  cdpl_div_pipe #(
    .LANES  (1),
    .NUM_W  (48),
    .DEN_W  (PW),
    .QW     (32),
    .SIDE_W ($bits(cdpl_pkg::limit_side_t))
  ) u_bud_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v5),
    .num       (bud_num),
    .den       (bud_den),
    .in_side   (side5),
    .out_valid (bv),
    .quo       (bud_q),
    .out_side  (bud_side)
  );

  cdpl_sqrt_pipe #(
    .RW     (16),
    .SIDE_W ($bits(cdpl_pkg::limit_side_t))
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (bv),
    .rad       (bud_q[0]),
    .in_side   (bud_side),
    .out_valid (sv),
    .root      (scale),
    .out_side  (sq_side)
  );

  // stage 6: apply power scale
  logic                v6;
  logic [15:0]         volt6;
  cdpl_pkg::out_side_t side6;
  cdpl_pkg::mag_vec_t  mag6_next;

  always_comb begin
    logic [31:0] prod;
    prod = '0;
    for (int l = 0; l < AX; l++) begin
      prod         = {16'd0, sq_side.mag[l]} * {16'd0, scale};
      mag6_next[l] = sq_side.limited ? prod[31:16] : sq_side.mag[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= sv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      volt6         <= sq_side.volt;
      side6.neg     <= sq_side.neg;
      side6.clamped <= sq_side.clamped;
      side6.limited <= sq_side.limited;
      side6.mag     <= mag6_next;
    end
  end

  // second power estimate on final duties
  logic                pe2_v;
  logic [PW-1:0]       pe2_power;
  cdpl_pkg::out_side_t pe2_side;

  cdpl_power_est #(
    .FRAC   (F),
    .SIDE_W ($bits(cdpl_pkg::out_side_t)),
    .PW     (PW)
  ) u_pe2 (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v6),
    .mag       (side6.mag),
    .volt      (volt6),
    .res       (cfg_res),
    .in_side   (side6),
    .out_valid (pe2_v),
    .power     (pe2_power),
    .out_side  (pe2_side)
  );

  // output register: duties, moments, saturated power
  logic [AX-1:0][15:0] duty_o;
  logic [AX-1:0][16:0] mom_o;
  logic [15:0]         pwr_o;
  logic                clamp_o;
  logic                lim_o;
  logic [AX-1:0][15:0] duty_next;
  logic [AX-1:0][16:0] mom_next;

  always_comb begin
    logic [31:0] mprod;
    logic [31:0] msh;
    logic [15:0] msat;
    mprod = '0;
    msh   = '0;
    msat  = '0;
    for (int l = 0; l < AX; l++) begin
      mprod        = {16'd0, pe2_side.mag[l]} * {16'd0, cfg_gain};
      msh          = mprod >> F;
      msat         = (msh > 32'd65535) ? 16'hFFFF : msh[15:0];
      duty_next[l] = pe2_side.neg[l] ? (16'd0 - pe2_side.mag[l]) : pe2_side.mag[l];
      mom_next[l]  = pe2_side.neg[l] ? (17'd0 - {1'b0, msat}) : {1'b0, msat};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= pe2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      duty_o  <= duty_next;
      mom_o   <= mom_next;
      pwr_o   <= (pe2_power > PW'(16'hFFFF)) ? 16'hFFFF : pe2_power[15:0];
      clamp_o <= pe2_side.clamped;
      lim_o   <= pe2_side.limited;
    end
  end

  assign m_tdata = {5'd0, pwr_o, mom_o[2], mom_o[1], mom_o[0], duty_o[2], duty_o[1], duty_o[0]};
  assign m_tuser = {lim_o, clamp_o};

  // duty magnitude never above full scale
  logic duty_ok;
  always_comb begin
    logic [15:0] a;
    a       = '0;
    duty_ok = 1'b1;
    for (int l = 0; l < AX; l++) begin
      a = duty_o[l][15] ? (16'd0 - duty_o[l]) : duty_o[l];
      if ({16'd0, a} > ONE32) begin
        duty_ok = 1'b0;
      end
    end
  end

  `CDPL_ASSERT_NEXT(a_accept_s1, s_tvalid && s_tready, v1, "accepted request not in stage 1")
  `CDPL_ASSERT_NOW(a_lim_power, v5 && lim5, p5 != '0, "power limit with zero power")
  `CDPL_ASSERT_NOW(a_duty_bound, m_tvalid, duty_ok, "duty above full scale")
  `CDPL_ASSERT_NOW(a_mom_sign, m_tvalid && (mom_o[0] != '0), mom_o[0][16] == duty_o[0][15],
    "moment sign differs from duty sign")

endmodule

`default_nettype wire

[tb/tb_coil_duty_power_limiter_unit.sv]
// testbench for the coil duty power limiter: directed table plus random duty requests
// checked against a behavioral predictor of clamp, power estimate and power scaling
// depends on cdpl_pkg and coil_duty_power_limiter_unit
`default_nettype none

module tb_coil_duty_power_limiter_unit;

  localparam int FRAC = cdpl_pkg::DUTY_FRAC_BITS_DEF;
  localparam int LAT = 184 - 3 * FRAC;
  localparam int N_RAND = 850;

  typedef struct packed {
    logic signed [15:0] dx, dy, dz;
    logic signed [16:0] mx, my, mz;
    logic [15:0] pwr;
    logic clamped, limited;
  } lim_out_t;

  typedef struct {
    logic [15:0] rx, ry, rz, volt;
    logic alive;
    bit has_exp;
    logic [15:0] edx, edy, edz, epwr;
    logic ecl, eli;
  } drow_t;

  logic clk, rst;
  logic s_tvalid, s_tready, s_tuser;
  logic [63:0] s_tdata;
  logic m_tvalid, m_tready;
  logic [119:0] m_tdata;
  logic [1:0] m_tuser;
  logic cfg_valid, cfg_ready;
  logic [cdpl_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [cdpl_pkg::CFG_W-1:0] cfg_data;

  logic [15:0] worst_v, res_x, res_y, res_z, budget, gain;
  lim_out_t duty_queue[$];
  int errors, n_sent, n_got;
  bit hold_rx, no_idle;

  coil_duty_power_limiter_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("** coil_duty_power_limiter_unit: FAILED **");
    $finish;
  end

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] coil_power(logic [63:0] m0, logic [63:0] m1,
                                             logic [63:0] m2, logic [63:0] v);
    logic [63:0] r[3], m[3], num, tot, one;
    one = 64'd1 << FRAC;
    m[0] = m0; m[1] = m1; m[2] = m2;
    r[0] = res_x ? res_x : 1; r[1] = res_y ? res_y : 1; r[2] = res_z ? res_z : 1;
    tot = 0;
    for (int i = 0; i < 3; i++) begin
      num = m[i] * v;
      tot = tot + (num * num) / (one * one * r[i]);
    end
    return tot;
  endfunction

  function automatic lim_out_t limit_duty(logic [15:0] rx, logic [15:0] ry,
                                          logic [15:0] rz, logic [15:0] bv, logic alive);
    logic [15:0] raw[3];
    logic [63:0] m[3], mx, one, v, p, s, mom;
    logic ng[3];
    logic signed [16:0] d[3], mo[3];
    lim_out_t o;
    raw[0] = rx; raw[1] = ry; raw[2] = rz;
    one = 64'd1 << FRAC;
    mx = 0;
    o.clamped = 0;
    o.limited = 0;
    for (int i = 0; i < 3; i++) begin
      ng[i] = raw[i][15];
      m[i] = ng[i] ? 64'h10000 - raw[i] : raw[i];
      if (m[i] > mx) mx = m[i];
    end
    v = alive ? bv : worst_v;
    if (mx > one) begin
      o.clamped = 1;
      for (int i = 0; i < 3; i++) m[i] = (2 * m[i] * one + mx) / (2 * mx);
    end
    p = coil_power(m[0], m[1], m[2], v);
    if (p > budget) begin
      s = root64((64'(budget) << 32) / p);
      o.limited = 1;
      for (int i = 0; i < 3; i++) m[i] = (m[i] * s) >> 16;
    end
    p = coil_power(m[0], m[1], m[2], v);
    o.pwr = p > 65535 ? 16'hFFFF : p[15:0];
    for (int i = 0; i < 3; i++) begin
      mom = (m[i] * gain) >> FRAC;
      if (mom > 65535) mom = 65535;
      d[i] = ng[i] ? -$signed({1'b0, m[i][15:0]}) : $signed({1'b0, m[i][15:0]});
      mo[i] = ng[i] ? -$signed({1'b0, mom[15:0]}) : $signed({1'b0, mom[15:0]});
    end
    o.dx = d[0][15:0]; o.dy = d[1][15:0]; o.dz = d[2][15:0];
    o.mx = mo[0]; o.my = mo[1]; o.mz = mo[2];
    return o;
  endfunction

  task automatic write_reg(cdpl_pkg::cfg_reg_t a, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_addr <= a;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (a)
      cdpl_pkg::CFG_WORST_V: worst_v = val;
      cdpl_pkg::CFG_RES_X:   res_x = val;
      cdpl_pkg::CFG_RES_Y:   res_y = val;
      cdpl_pkg::CFG_RES_Z:   res_z = val;
      cdpl_pkg::CFG_BUDGET:  budget = val;
      cdpl_pkg::CFG_GAIN:    gain = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (duty_queue.size() != 0) @(negedge clk);
    repeat (LAT + 10) @(negedge clk);
  endtask

  task automatic send_request(logic [15:0] rx, logic [15:0] ry, logic [15:0] rz,
                              logic [15:0] bv, logic alive, bit idle_ok);
    while (idle_ok && !no_idle && $urandom_range(99) < 31) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {bv, rz, ry, rx};
    s_tuser <= alive;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    duty_queue.push_back(limit_duty(rx, ry, rz, bv, alive));
    n_sent++;
    @(negedge clk);
  endtask

  task automatic send_random(int kind);
    logic [15:0] r[3];
    for (int i = 0; i < 3; i++)
      case (kind)
        0: r[i] = 16'($urandom);
        1: r[i] = 16'($urandom_range(32768) - 16384);
        default: r[i] = 16'($urandom_range(600) - 300);
      endcase
    send_request(r[0], r[1], r[2], 16'($urandom), 1'($urandom_range(1)), 1'b1);
  endtask

  // receiver: random stall unless held off or in the no-idle stretch
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else begin
      m_tready <= !hold_rx && (no_idle || $urandom_range(99) >= 31);
    end
  end

  always @(posedge clk) begin
    lim_out_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[64:48],
             m_tdata[81:65], m_tdata[98:82], m_tdata[114:99], m_tuser[0], m_tuser[1]};
      n_got++;
      if (duty_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        want = duty_queue.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch exp d=%0d/%0d/%0d m=%0d/%0d/%0d p=%0d c=%b l=%b",
              want.dx, want.dy, want.dz, want.mx, want.my, want.mz, want.pwr,
              want.clamped, want.limited);
            $display("         got d=%0d/%0d/%0d m=%0d/%0d/%0d p=%0d c=%b l=%b",
              got.dx, got.dy, got.dz, got.mx, got.my, got.mz, got.pwr,
              got.clamped, got.limited);
          end
        end
      end
    end
  end

  initial begin
    drow_t dir[$];
    lim_out_t p;
    errors = 0; n_sent = 0; n_got = 0;
    hold_rx = 0; no_idle = 0;
    rst = 1;
    s_tvalid = 0; s_tdata = 0; s_tuser = 0;
    cfg_valid = 0; cfg_addr = cdpl_pkg::CFG_WORST_V; cfg_data = 0;
    worst_v = cdpl_pkg::RST_WORST_V; res_x = cdpl_pkg::RST_RES;
    res_y = cdpl_pkg::RST_RES; res_z = cdpl_pkg::RST_RES;
    budget = cdpl_pkg::RST_BUDGET; gain = cdpl_pkg::RST_GAIN;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // zero request, extremes, clamp ties, monitor dead, voltage zero
    dir = '{
      '{16'h0000, 16'h0000, 16'h0000, 16'd5000, '1, '1, 16'h0000, 16'h0000, 16'h0000, '0, '0, '0},
      '{16'h4000, 16'h0000, 16'h0000, 16'd0, '1, '1, 16'h4000, 16'h0000, 16'h0000, '0, '0, '0},
      '{16'h8000, 16'h0000, 16'h0000, 16'd0, '1, '1, 16'hC000, 16'h0000, 16'h0000, '0, '1, '0},
      '{16'h7FFF, 16'h8000, 16'h0001, 16'd0, '1, '1, 16'h4000, 16'hC000, 16'h0001, '0, '1, '0},
      '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, '1, '0, '0, '0, '0, '0, '0, '0},
      '{16'h8000, 16'h8000, 16'h8000, 16'hFFFF, '0, '0, '0, '0, '0, '0, '0, '0},
      '{16'h4000, 16'hC000, 16'h2000, 16'd100, '0, '0, '0, '0, '0, '0, '0, '0},
      '{16'h1000, 16'h0800, 16'hF800, 16'd3000, '1, '0, '0, '0, '0, '0, '0, '0},
      '{16'h4001, 16'h2000, 16'h0000, 16'd1000, '1, '0, '0, '0, '0, '0, '0, '0},
      '{16'hFFFF, 16'h0001, 16'h8001, 16'hFFFF, '0, '0, '0, '0, '0, '0, '0, '0}
    };
    foreach (dir[i]) begin
      if (dir[i].has_exp) begin
        p = limit_duty(dir[i].rx, dir[i].ry, dir[i].rz, dir[i].volt, dir[i].alive);
        if (p.dx !== dir[i].edx || p.dy !== dir[i].edy || p.dz !== dir[i].edz ||
            p.pwr !== dir[i].epwr || p.clamped !== dir[i].ecl || p.limited !== dir[i].eli) begin
          errors++;
          $display("table row %0d disagrees with prediction", i);
        end
      end
      send_request(dir[i].rx, dir[i].ry, dir[i].rz, dir[i].volt, dir[i].alive, 1'b0);
    end
    drain_results();

    // zero resistance, zero budget, full gain, full-scale worst-case voltage
    write_reg(cdpl_pkg::CFG_RES_X, 16'd0);
    write_reg(cdpl_pkg::CFG_BUDGET, 16'd0);
    write_reg(cdpl_pkg::CFG_GAIN, 16'hFFFF);
    write_reg(cdpl_pkg::CFG_WORST_V, 16'hFFFF);
    send_request(16'h4000, 16'h0000, 16'h0000, 16'd0, 1'b0, 1'b0);
    send_request(16'h0000, 16'h0000, 16'h0000, 16'd0, 1'b0, 1'b0);
    send_request(16'h8000, 16'h7FFF, 16'h1234, 16'd5, 1'b1, 1'b0);
    drain_results();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(cdpl_pkg::CFG_WORST_V, cdpl_pkg::RST_WORST_V);
          write_reg(cdpl_pkg::CFG_RES_X, cdpl_pkg::RST_RES);
          write_reg(cdpl_pkg::CFG_RES_Y, cdpl_pkg::RST_RES);
          write_reg(cdpl_pkg::CFG_RES_Z, cdpl_pkg::RST_RES);
          write_reg(cdpl_pkg::CFG_BUDGET, cdpl_pkg::RST_BUDGET);
          write_reg(cdpl_pkg::CFG_GAIN, cdpl_pkg::RST_GAIN);
        end
        1: begin
          write_reg(cdpl_pkg::CFG_RES_Y, 16'd1); write_reg(cdpl_pkg::CFG_RES_Z, 16'hFFFF);
          write_reg(cdpl_pkg::CFG_BUDGET, 16'hFFFF); write_reg(cdpl_pkg::CFG_WORST_V, 16'd0);
        end
        default: begin
          write_reg(cdpl_pkg::CFG_WORST_V, 16'($urandom));
          write_reg(cdpl_pkg::CFG_RES_X, 16'($urandom_range(65535, 1)));
          write_reg(cdpl_pkg::CFG_RES_Y, 16'($urandom_range(65535, 1)));
          write_reg(cdpl_pkg::CFG_RES_Z, 16'($urandom_range(65535, 1)));
          write_reg(cdpl_pkg::CFG_BUDGET, 16'($urandom));
          write_reg(cdpl_pkg::CFG_GAIN, 16'($urandom));
        end
      endcase
      no_idle = (ph == 2);
      for (int k = 0; k < N_RAND / 5; k++) begin
        if (ph == 3 && k == 20) begin
          fork
            begin
              hold_rx = 1;
              repeat (LAT + 300) @(negedge clk);
              hold_rx = 0;
            end
          join_none
        end
        if (ph == 4 && k == 60) begin
          s_tvalid <= 1'b0;
          do @(negedge clk); while (duty_queue.size() != 0);
        end
        send_random($urandom_range(2));
      end
      drain_results();
    end

    $display("sent %0d duty requests over several register settings, %0d results checked",
             n_sent, n_got);
    if (errors == 0 && duty_queue.size() == 0) begin
      $display("** coil_duty_power_limiter_unit: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, duty_queue.size());
      $display("** coil_duty_power_limiter_unit: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
